// ===== rtl/adaptive_mains_notch_unit_assert.svh =====
// Assertion macros for the adaptive mains notch unit.
// Included by the top level; needs nothing else.
`ifndef ADAPTIVE_MAINS_NOTCH_UNIT_ASSERT_SVH
`define ADAPTIVE_MAINS_NOTCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition or property that must hold at every edge out of reset
`define AMN_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// antecedent in this cycle implies consequent in the next one
`define AMN_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AMN_CHECK(label, clk, rst_n, prop, msg)
`define AMN_CHECK_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/amn_pkg.sv =====
// Package for the adaptive mains notch unit: widths, payload types,
// sequencer states and the Q1.15 sine table. No dependencies.
package amn_pkg;

	// field and state widths
	localparam int SAMPLE_BITS = 24;
	localparam int W_W         = 40;
	localparam int P_W         = 32;
	localparam int S_W         = 16;
	localparam int FF_W        = 16;
	localparam int CLIP_W      = 23;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 23;

	// datapath widths
	localparam int ERR_W       = 28;
	localparam int MUL_A_W     = 41;
	localparam int MUL_B_W     = 17;
	localparam int MUL_W       = MUL_A_W + MUL_B_W;
	localparam int DVD_W       = 48;
	localparam int Q_W         = 40;
	localparam int DIV_SAT_SH  = 15;
	localparam int DIV_FRAC    = Q_W - DIV_SAT_SH;
	localparam int DIV_CNT_W   = 6;
	localparam int SQ_SH       = 6;
	localparam int PWR_SH      = 16;
	localparam int PRED_SH     = 31;
	localparam int IDX_W       = 5;
	localparam int PH_MAX_W    = 6;
	localparam int SINE_ENTRIES = 20;

	localparam logic [P_W-1:0]          POWER_ONE  = 32'h0100_0000;
	localparam logic [Q_W-1:0]          STEP_MAX   = '1;
	localparam logic [FF_W-1:0]         FF_RESET   = 16'd65274;
	localparam logic [CLIP_W-1:0]       CLIP_RESET = 23'h7F_FFFF;
	localparam logic signed [MUL_W-1:0] PRED_ROUND = MUL_W'(64'h4000_0000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          block_start;
		logic                          restart;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] clean_sample;
		logic                          clipped;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED_S,
		ST_PRED_C,
		ST_PWR_S,
		ST_SQR_S,
		ST_PWR_C,
		ST_SQR_C,
		ST_POW_WR,
		ST_STEP_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_W_UPD,
		ST_FIN
	} state_t;

	// table index modulo the number of sine entries
	function automatic logic [IDX_W-1:0] mod_entries(input logic [PH_MAX_W-1:0] v);
		logic [PH_MAX_W-1:0] r;
		r = v;
		for (int k = 0; k < 3; k++) begin
			if (r >= PH_MAX_W'(SINE_ENTRIES))
				r = r - PH_MAX_W'(SINE_ENTRIES);
		end
		return r[IDX_W-1:0];
	endfunction

	// one mains period in Q1.15, full scale held as 32767
	function automatic logic signed [S_W-1:0] sine_q15(input logic [IDX_W-1:0] idx);
		logic signed [S_W-1:0] s;
		unique case (idx)
			5'd0:    s = 16'sd0;
			5'd1:    s = 16'sd10126;
			5'd2:    s = 16'sd19261;
			5'd3:    s = 16'sd26510;
			5'd4:    s = 16'sd31164;
			5'd5:    s = 16'sd32767;
			5'd6:    s = 16'sd31164;
			5'd7:    s = 16'sd26510;
			5'd8:    s = 16'sd19261;
			5'd9:    s = 16'sd10126;
			5'd10:   s = 16'sd0;
			5'd11:   s = -16'sd10126;
			5'd12:   s = -16'sd19261;
			5'd13:   s = -16'sd26510;
			5'd14:   s = -16'sd31164;
			5'd15:   s = -16'sd32767;
			5'd16:   s = -16'sd31164;
			5'd17:   s = -16'sd26510;
			5'd18:   s = -16'sd19261;
			5'd19:   s = -16'sd10126;
			default: s = 16'sd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/amn_div.sv =====
// Restoring divider for the weight step: floor(dividend * 2^25 / divisor),
// limited to 40 bits, one quotient bit per cycle. Depends on amn_pkg.
module amn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [amn_pkg::DVD_W-1:0]  dividend,
	input  logic [amn_pkg::P_W-1:0]    divisor,
	output amn_pkg::div_stat_t         stat,
	output logic [amn_pkg::Q_W-1:0]    quotient
);
	import amn_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [P_W-1:0]       rem_q;
	logic [P_W-1:0]       dvs_q;
	logic [Q_W-1:0]       quo_q;
	logic [P_W+1:0]       diff;
	logic                 sat;

	// result overflows 40 bits exactly when dividend >= divisor * 2^15
	assign sat = dividend >= (DVD_W'(divisor) << DIV_SAT_SH);

	// trial subtract of the next partial remainder
	assign diff = {1'b0, rem_q, quo_q[Q_W-1]} - {2'b00, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= DIV_CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quo_q shifts dividend bits out at the top, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			if (sat) begin
				quo_q <= STEP_MAX;
			end else begin
				rem_q <= P_W'(dividend >> DIV_SAT_SH);
				quo_q <= {dividend[DIV_SAT_SH-1:0], {DIV_FRAC{1'b0}}};
			end
		end else if (busy_q) begin
			if (!diff[P_W+1])
				rem_q <= diff[P_W-1:0];
			else
				rem_q <= {rem_q[P_W-2:0], quo_q[Q_W-1]};
			quo_q <= {quo_q[Q_W-2:0], !diff[P_W+1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== rtl/adaptive_mains_notch_unit.sv =====
// Adaptive mains notch: one multiplier and one divider under a sequencer.
// Depends on amn_pkg, amn_div and adaptive_mains_notch_unit_assert.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one sample with block_start and restart.
//   out_valid/out_ready/out_data return the cleaned sample and clip flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write forgetting_factor (0) and
//   clip_limit (1); cfg_ready is always high; user keeps writes to idle.
// Timing:
//   A sample is taken only in the idle state. The states PRED_S through
//   POW_WR form the prediction, error and both power updates on the shared
//   41x17 multiplier, then each weight takes a step multiply, the 40-step
//   restoring divider and a write; a new sample is taken only once the last
//   result is loaded. A zero reference, power or error skips the divider;
//   an overflowing step saturates without the divider's bit steps.
// Reset: weights clear, powers set to one, phase zero, registers to defaults.
// Stall: the result sits in an output register; the next sample is taken
//   meanwhile, and a second result waits in the final state until it frees.
`include "adaptive_mains_notch_unit_assert.svh"

module adaptive_mains_notch_unit #(
	parameter int TABLE_LEN = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  amn_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output amn_pkg::out_item_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [amn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [amn_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import amn_pkg::*;

	localparam int PH_W    = $clog2(TABLE_LEN);
	localparam int COS_OFF = TABLE_LEN / 4;

	state_t state_q, state_d;

	logic [FF_W-1:0]               ff_q;
	logic [CLIP_W-1:0]             clip_q;
	logic signed [W_W-1:0]         w_sin_q, w_cos_q;
	logic [P_W-1:0]                p_sin_q, p_cos_q;
	logic [PH_W-1:0]               phase_q;
	logic                          sel_q;
	logic                          skip_q;
	logic                          out_valid_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [S_W-1:0]         si_q, sj_q;
	logic signed [MUL_W-1:0]       mul_q;
	logic signed [MUL_W-1:0]       acc_q;
	logic signed [ERR_W-1:0]       err_q;
	logic [P_W-1:0]                pw_q;
	out_item_t                     out_q;

	logic                          accept;
	logic [PH_W-1:0]               ph_start, ph_next, ci;
	logic [PH_W:0]                 ci_wide;
	logic signed [S_W-1:0]         s_sel;
	logic signed [W_W-1:0]         w_sel;
	logic [P_W-1:0]                p_sel;
	logic [ERR_W-1:0]              emag;
	logic [S_W-1:0]                smag;
	logic signed [MUL_A_W-1:0]     mul_a;
	logic signed [MUL_B_W-1:0]     mul_b;
	logic [P_W:0]                  pwr_sum;
	logic [P_W-1:0]                pwr_sat;
	logic                          step_neg;
	logic signed [W_W+1:0]         w_wide;
	logic signed [W_W-1:0]         w_new;
	logic                          skip_now;
	logic signed [ERR_W-1:0]       lim;
	logic signed [ERR_W-1:0]       res;
	logic                          clip_hit;
	logic                          out_load;
	logic                          div_start;
	div_stat_t                     div_stat;
	logic [Q_W-1:0]                div_quo;

	assign accept = in_valid && in_ready;

	// table phase for this sample and its cosine tap
	always_comb begin
		ph_start = in_data.block_start ? '0 : phase_q;
		ci_wide  = {1'b0, ph_start} + (PH_W+1)'(COS_OFF);
		if (ci_wide >= (PH_W+1)'(TABLE_LEN))
			ci = PH_W'(ci_wide - (PH_W+1)'(TABLE_LEN));
		else
			ci = PH_W'(ci_wide);
		ph_next = (ph_start == PH_W'(TABLE_LEN - 1)) ? '0 : ph_start + 1'b1;
	end

	// per-weight operand selection
	assign s_sel = sel_q ? sj_q : si_q;
	assign w_sel = sel_q ? w_cos_q : w_sin_q;
	assign p_sel = sel_q ? p_cos_q : p_sin_q;
	assign emag  = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign smag  = s_sel[S_W-1] ? S_W'(-s_sel) : S_W'(s_sel);
	assign skip_now = (p_sel == '0) || (s_sel == '0) || (err_q == '0);

	// decayed power plus scaled square, saturated to 32 bits
	assign pwr_sum = {1'b0, pw_q} + (P_W+1)'(mul_q[2*S_W-2:SQ_SH]);
	assign pwr_sat = pwr_sum[P_W] ? '1 : pwr_sum[P_W-1:0];

	// weight step applied with saturation to 40 bits
	assign step_neg = err_q[ERR_W-1] ^ s_sel[S_W-1];
	always_comb begin
		if (step_neg)
			w_wide = (W_W+2)'(w_sel) - $signed((W_W+2)'(div_quo));
		else
			w_wide = (W_W+2)'(w_sel) + $signed((W_W+2)'(div_quo));
		if (w_wide[W_W+1:W_W-1] == 3'b000 || w_wide[W_W+1:W_W-1] == 3'b111)
			w_new = w_wide[W_W-1:0];
		else if (w_wide[W_W+1])
			w_new = {1'b1, {(W_W-1){1'b0}}};
		else
			w_new = {1'b0, {(W_W-1){1'b1}}};
	end

	// output clip against +-clip_limit
	always_comb begin
		lim      = $signed(ERR_W'(clip_q));
		res      = err_q;
		clip_hit = 1'b0;
		if (err_q > lim) begin
			res      = lim;
			clip_hit = 1'b1;
		end else if (err_q < -lim) begin
			res      = -lim;
			clip_hit = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept) state_d = ST_PRED_S;
			ST_PRED_S:   state_d = ST_PRED_C;
			ST_PRED_C:   state_d = ST_PWR_S;
			ST_PWR_S:    state_d = ST_SQR_S;
			ST_SQR_S:    state_d = ST_PWR_C;
			ST_PWR_C:    state_d = ST_SQR_C;
			ST_SQR_C:    state_d = ST_POW_WR;
			ST_POW_WR:   state_d = ST_STEP_MUL;
			ST_STEP_MUL: state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = skip_now ? ST_W_UPD : ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_stat.done) state_d = ST_W_UPD;
			ST_W_UPD:    state_d = sel_q ? ST_FIN : ST_STEP_MUL;
			ST_FIN:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and shared multiplier operands
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_PRED_S: begin
				mul_a = MUL_A_W'(w_sin_q);
				mul_b = MUL_B_W'(si_q);
			end
			ST_PRED_C: begin
				mul_a = MUL_A_W'(w_cos_q);
				mul_b = MUL_B_W'(sj_q);
			end
			ST_PWR_S: begin
				mul_a = $signed(MUL_A_W'(p_sin_q));
				mul_b = $signed(MUL_B_W'(ff_q));
			end
			ST_SQR_S: begin
				mul_a = MUL_A_W'(si_q);
				mul_b = MUL_B_W'(si_q);
			end
			ST_PWR_C: begin
				mul_a = $signed(MUL_A_W'(p_cos_q));
				mul_b = $signed(MUL_B_W'(ff_q));
			end
			ST_SQR_C: begin
				mul_a = MUL_A_W'(sj_q);
				mul_b = MUL_B_W'(sj_q);
			end
			ST_STEP_MUL: begin
				mul_a = $signed(MUL_A_W'(emag));
				mul_b = $signed(MUL_B_W'(smag));
			end
			ST_DIV_GO:   div_start = !skip_now;
			ST_FIN:      out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ff_q        <= FF_RESET;
			clip_q      <= CLIP_RESET;
			w_sin_q     <= '0;
			w_cos_q     <= '0;
			p_sin_q     <= POWER_ONE;
			p_cos_q     <= POWER_ONE;
			phase_q     <= '0;
			sel_q       <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FORGET: ff_q   <= cfg_data[FF_W-1:0];
					REG_CLIP:   clip_q <= cfg_data[CLIP_W-1:0];
				endcase
			end

			if (accept) begin
				phase_q <= ph_next;
				sel_q   <= 1'b0;
				if (in_data.restart) begin
					w_sin_q <= '0;
					w_cos_q <= '0;
					p_sin_q <= POWER_ONE;
					p_cos_q <= POWER_ONE;
				end
			end

			unique case (state_q)
				ST_PWR_C:  p_sin_q <= pwr_sat;
				ST_POW_WR: p_cos_q <= pwr_sat;
				ST_DIV_GO: skip_q  <= skip_now;
				ST_W_UPD: begin
					if (!skip_q) begin
						if (sel_q)
							w_cos_q <= w_new;
						else
							w_sin_q <= w_new;
					end
					sel_q <= 1'b1;
				end
				default: ;
			endcase

			// output register
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (accept) begin
			x_q  <= in_data.sample;
			si_q <= sine_q15(mod_entries(PH_MAX_W'(ph_start)));
			sj_q <= sine_q15(mod_entries(PH_MAX_W'(ci)));
		end
		unique case (state_q)
			ST_PRED_C: acc_q <= mul_q + PRED_ROUND;
			ST_PWR_S:  acc_q <= acc_q + mul_q;
			ST_SQR_S: begin
				err_q <= ERR_W'(x_q) - ERR_W'($signed(acc_q[MUL_W-1:PRED_SH]));
				pw_q  <= mul_q[P_W+PWR_SH-1:PWR_SH];
			end
			ST_SQR_C:  pw_q <= mul_q[P_W+PWR_SH-1:PWR_SH];
			default: ;
		endcase
		if (out_load) begin
			out_q.clean_sample <= res[SAMPLE_BITS-1:0];
			out_q.clipped      <= clip_hit;
		end
	end

	amn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_q[DVD_W-1:0]),
		.divisor  (p_sel),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// checks
	`AMN_CHECK_NEXT(a_busy_after_xfer, clk, arst_n, in_valid && in_ready, !in_ready, "ready after transfer")
	`AMN_CHECK_NEXT(a_restart_state, clk, arst_n, in_valid && in_ready && in_data.restart, p_sin_q == POWER_ONE && p_cos_q == POWER_ONE && w_sin_q == '0, "restart not applied")
	`AMN_CHECK_NEXT(a_fin_load, clk, arst_n, state_q == ST_FIN && out_load, out_valid && state_q == ST_IDLE, "result not loaded")
	`AMN_CHECK(a_done_in_wait, clk, arst_n, !div_stat.done || state_q == ST_DIV_WAIT, "divider done outside wait")

endmodule
